FILE: hw/rtl/raa_pkg.sv
// raa_pkg: shared types, constants and helper functions for the rectangle atlas allocator
// no dependencies; used by raa_free_mem, raa_engine and rect_atlas_allocator
`timescale 1ns / 1ps
`default_nettype none

package raa_pkg;

    localparam int COORD_BITS          = 13;
    localparam int FREE_LIST_DEPTH_DEF = 64;
    localparam int CFG_INDEX_BITS      = 3;
    localparam int STATUS_BITS         = 2;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    // register indexes on the config port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST_MODE   = 3'd4;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_PLACED   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_LOST     = 2'd2;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   dead;
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } rect_t;

    typedef struct packed {
        coord_t req_width;
        coord_t req_height;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        coord_t                 pos_x;
        coord_t                 pos_y;
    } res_t;

    typedef struct packed {
        coord_t init_width;
        coord_t init_height;
        coord_t max_width;
        coord_t max_height;
        logic   fast_mode;
    } cfg_t;

    // double a canvas dimension, saturating at the coordinate range
    function automatic coord_t doubled(input coord_t v);
        logic [COORD_BITS:0] d;
        d = {v, 1'b0};
        return (d > {1'b0, COORD_MAX}) ? COORD_MAX : d[COORD_BITS-1:0];
    endfunction

    // true when outer holds inner
    function automatic logic contains(input rect_t outer, input rect_t inner);
        return (inner.left >= outer.left) && (inner.top >= outer.top) &&
               (inner.right <= outer.right) && (inner.bottom <= outer.bottom);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/raa_free_mem.sv
// raa_free_mem: two banks of free rectangle storage, one write and one registered read per cycle
// depends on raa_pkg for the rectangle type
`timescale 1ns / 1ps
`default_nettype none

module raa_free_mem #(
    parameter int FREE_LIST_DEPTH = raa_pkg::FREE_LIST_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               wr_en,
    input  wire logic                               wr_bank,
    input  wire logic [$clog2(FREE_LIST_DEPTH)-1:0] wr_addr,
    input  wire raa_pkg::rect_t                     wr_data,
    input  wire logic                               rd_bank,
    input  wire logic [$clog2(FREE_LIST_DEPTH)-1:0] rd_addr,
    output raa_pkg::rect_t                          rd_data
);

    raa_pkg::rect_t bank0_mem [FREE_LIST_DEPTH];
    raa_pkg::rect_t bank1_mem [FREE_LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_bank)
        begin
            bank0_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_bank)
        begin
            bank1_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_bank)
        begin
            rd_data <= bank1_mem[rd_addr];
        end
        else
        begin
            rd_data <= bank0_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/raa_engine.sv
// raa_engine: sequencer for search, canvas growth, split, exact cut, cleanup and compaction
// depends on raa_pkg; drives the ports of raa_free_mem
`timescale 1ns / 1ps
`default_nettype none

module raa_engine #(
    parameter int FREE_LIST_DEPTH = raa_pkg::FREE_LIST_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire raa_pkg::cfg_t                      cfg,
    input  wire logic                               clear,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire raa_pkg::req_t                      in_data,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output raa_pkg::res_t                           res_data,
    output logic                                    wr_en,
    output logic                                    wr_bank,
    output logic [$clog2(FREE_LIST_DEPTH)-1:0]      wr_addr,
    output raa_pkg::rect_t                          wr_data,
    output logic                                    rd_bank,
    output logic [$clog2(FREE_LIST_DEPTH)-1:0]      rd_addr,
    input  wire raa_pkg::rect_t                     rd_data
);

    localparam int CB = raa_pkg::COORD_BITS;
    localparam int AW = $clog2(FREE_LIST_DEPTH);
    localparam int CW = $clog2(FREE_LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FREE_LIST_DEPTH);
    localparam logic [CW:0]   DEPTH_X = (CW + 1)'(FREE_LIST_DEPTH);

    localparam logic [1:0] PC_RIGHT  = 2'd0;
    localparam logic [1:0] PC_LEFT   = 2'd1;
    localparam logic [1:0] PC_BOTTOM = 2'd2;
    localparam logic [1:0] PC_TOP    = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EV, S_GROW, S_PICK_RD, S_PICK_EV, S_FAST_PUSH,
        S_CUT_RD, S_CUT_EV, S_PIECE, S_DROP_I_RD, S_DROP_I_EV, S_DROP_J_RD,
        S_DROP_J_EV, S_PACK_RD, S_PACK_EV, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                cur_reg, cur_next;
    raa_pkg::coord_t     cw_reg, cw_next;
    raa_pkg::coord_t     ch_reg, ch_next;
    logic                gw_reg, gw_next;
    logic                pend_reg, pend_next;
    logic                lost_reg, lost_next;
    logic                fail_reg, fail_next;
    logic                found_reg, found_next;
    logic                pass_reg, pass_next;
    logic [1:0]          piece_reg, piece_next;
    raa_pkg::coord_t     w_reg, w_next;
    raa_pkg::coord_t     h_reg, h_next;
    raa_pkg::coord_t     x_reg, x_next;
    raa_pkg::coord_t     y_reg, y_next;
    raa_pkg::coord_t     rr_reg, rr_next;
    raa_pkg::coord_t     rb_reg, rb_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       jdx_reg, jdx_next;
    logic [CW-1:0]       best_reg, best_next;
    logic [2*CB-1:0]     area_reg, area_next;
    logic [CW-1:0]       kept_reg, kept_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       pcnt_reg, pcnt_next;
    raa_pkg::rect_t      e0_reg, e0_next;
    raa_pkg::rect_t      ov_reg, ov_next;
    raa_pkg::rect_t      ri_reg, ri_next;

    // per-entry datapath on the read word
    raa_pkg::coord_t     fit_w, fit_h;
    logic                fits;
    logic [2*CB-1:0]     fit_area;
    logic [CB:0]         rr_sum, rb_sum;
    logic                overlap;
    logic                split;
    logic                can_push;
    logic                piece_room;
    logic                piece_take;
    raa_pkg::rect_t      piece_rect;
    logic [CW-1:0]       piece_addr;
    raa_pkg::coord_t     dbl_w, dbl_h;
    logic                e0_whole;

    assign fit_w    = rd_data.right - rd_data.left;
    assign fit_h    = rd_data.bottom - rd_data.top;
    assign fits     = (rd_data.right >= rd_data.left) && (rd_data.bottom >= rd_data.top) &&
                      (fit_w >= w_reg) && (fit_h >= h_reg);
    assign fit_area = fit_w * fit_h;
    assign rr_sum   = {1'b0, rd_data.left} + {1'b0, w_reg};
    assign rb_sum   = {1'b0, rd_data.top} + {1'b0, h_reg};
    assign overlap  = (rr_reg > rd_data.left) && (x_reg < rd_data.right) &&
                      (rb_reg > rd_data.top) && (y_reg < rd_data.bottom);
    assign split    = ({1'b0, rd_data.bottom - rd_data.top} > {h_reg, 1'b0}) ||
                      (h_reg >= (ch_reg >> 1));
    assign can_push = cnt_reg < DEPTH_C;
    assign piece_room = (({1'b0, cnt_reg} - {1'b0, rem_reg}) + {1'b0, pcnt_reg}) < DEPTH_X;
    assign piece_addr = kept_reg + pcnt_reg;
    assign dbl_w    = raa_pkg::doubled(cw_reg);
    assign dbl_h    = raa_pkg::doubled(ch_reg);
    assign e0_whole = (cnt_reg == CW'(1)) && (e0_reg.left == '0) && (e0_reg.top == '0);

    // leftover pieces of an overlapped area around the reservation
    always_comb
    begin
        piece_rect      = ov_reg;
        piece_rect.dead = 1'b0;
        unique case (piece_reg)
            PC_RIGHT:
            begin
                piece_take      = rr_reg < ov_reg.right;
                piece_rect.left = rr_reg;
            end
            PC_LEFT:
            begin
                piece_take       = x_reg > ov_reg.left;
                piece_rect.right = x_reg;
            end
            PC_BOTTOM:
            begin
                piece_take     = rb_reg < ov_reg.bottom;
                piece_rect.top = rb_reg;
            end
            default:
            begin
                piece_take        = y_reg > ov_reg.top;
                piece_rect.bottom = y_reg;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) && !pend_reg && !clear;
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res_data.status = fail_reg ? raa_pkg::ST_NO_SPACE :
                          (lost_reg ? raa_pkg::ST_LOST : raa_pkg::ST_PLACED);
        res_data.pos_x  = x_reg;
        res_data.pos_y  = y_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        cw_next    = cw_reg;
        ch_next    = ch_reg;
        gw_next    = gw_reg;
        pend_next  = pend_reg;
        lost_next  = lost_reg;
        fail_next  = fail_reg;
        found_next = found_reg;
        pass_next  = pass_reg;
        piece_next = piece_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rr_next    = rr_reg;
        rb_next    = rb_reg;
        idx_next   = idx_reg;
        jdx_next   = jdx_reg;
        best_next  = best_reg;
        area_next  = area_reg;
        kept_next  = kept_reg;
        rem_next   = rem_reg;
        pcnt_next  = pcnt_reg;
        e0_next    = e0_reg;
        ov_next    = ov_reg;
        ri_next    = ri_reg;

        wr_en   = 1'b0;
        wr_bank = cur_reg;
        wr_addr = '0;
        wr_data = '0;
        rd_bank = cur_reg;
        rd_addr = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (pend_reg)
                begin
                    // seed the list with the whole initial canvas
                    wr_en          = 1'b1;
                    wr_data.right  = cfg.init_width;
                    wr_data.bottom = cfg.init_height;
                    cw_next        = cfg.init_width;
                    ch_next        = cfg.init_height;
                    pend_next      = 1'b0;
                end
                else if (in_valid && in_ready)
                begin
                    w_next     = in_data.req_width;
                    h_next     = in_data.req_height;
                    lost_next  = 1'b0;
                    fail_next  = 1'b0;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = found_reg ? S_PICK_RD : S_GROW;
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end

            S_SCAN_EV:
            begin
                if (idx_reg == '0)
                begin
                    e0_next = rd_data;
                end
                if (fits && (!found_reg || (fit_area < area_reg)))
                begin
                    found_next = 1'b1;
                    best_next  = idx_reg;
                    area_next  = fit_area;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_SCAN_RD;
            end

            S_GROW:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                state_next = S_SCAN_RD;
                if (gw_reg && (cw_reg != '0) && (cw_reg < cfg.max_width))
                begin
                    cw_next = dbl_w;
                    gw_next = 1'b0;
                    if (e0_whole && (e0_reg.right == cw_reg) && (e0_reg.bottom == ch_reg))
                    begin
                        wr_en         = 1'b1;
                        wr_data       = e0_reg;
                        wr_data.right = dbl_w;
                    end
                    else if (can_push)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = cnt_reg[AW-1:0];
                        wr_data.left   = cw_reg;
                        wr_data.right  = dbl_w;
                        wr_data.bottom = ch_reg;
                        cnt_next       = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                end
                else if (!gw_reg && (ch_reg != '0) && (ch_reg < cfg.max_height))
                begin
                    ch_next = dbl_h;
                    gw_next = 1'b1;
                    if (e0_whole && (e0_reg.right == cw_reg) && (e0_reg.bottom == ch_reg))
                    begin
                        wr_en          = 1'b1;
                        wr_data        = e0_reg;
                        wr_data.bottom = dbl_h;
                    end
                    else if (can_push)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = cnt_reg[AW-1:0];
                        wr_data.top    = ch_reg;
                        wr_data.right  = cw_reg;
                        wr_data.bottom = dbl_h;
                        cnt_next       = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                end
                else
                begin
                    fail_next  = 1'b1;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = S_DONE;
                end
            end

            S_PICK_RD:
            begin
                rd_addr    = best_reg[AW-1:0];
                state_next = S_PICK_EV;
            end

            S_PICK_EV:
            begin
                x_next  = rd_data.left;
                y_next  = rd_data.top;
                rr_next = rr_sum[CB-1:0];
                rb_next = rb_sum[CB-1:0];
                if (cfg.fast_mode)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = best_reg[AW-1:0];
                    wr_data      = rd_data;
                    wr_data.left = rr_sum[CB-1:0];
                    if (split)
                    begin
                        wr_data.bottom = rb_sum[CB-1:0];
                        ov_next        = rd_data;
                        ov_next.top    = rb_sum[CB-1:0];
                        state_next     = S_FAST_PUSH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    kept_next  = '0;
                    rem_next   = '0;
                    pcnt_next  = '0;
                    pass_next  = 1'b0;
                    state_next = S_CUT_RD;
                end
            end

            S_FAST_PUSH:
            begin
                if (can_push)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cnt_reg[AW-1:0];
                    wr_data  = ov_reg;
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    lost_next = 1'b1;
                end
                state_next = S_DONE;
            end

            S_CUT_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    idx_next = '0;
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        rem_next   = '0;
                        state_next = S_CUT_RD;
                    end
                    else
                    begin
                        cnt_next   = kept_reg + pcnt_reg;
                        cur_next   = !cur_reg;
                        state_next = S_DROP_I_RD;
                    end
                end
                else
                begin
                    state_next = S_CUT_EV;
                end
            end

            S_CUT_EV:
            begin
                if (!pass_reg)
                begin
                    // first pass copies the untouched areas in order
                    if (!overlap)
                    begin
                        wr_en     = 1'b1;
                        wr_bank   = !cur_reg;
                        wr_addr   = kept_reg[AW-1:0];
                        wr_data   = rd_data;
                        kept_next = kept_reg + CW'(1);
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_CUT_RD;
                end
                else if (overlap)
                begin
                    rem_next   = rem_reg + CW'(1);
                    ov_next    = rd_data;
                    piece_next = PC_RIGHT;
                    state_next = S_PIECE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_CUT_RD;
                end
            end

            S_PIECE:
            begin
                if (piece_take)
                begin
                    if (piece_room)
                    begin
                        wr_en     = 1'b1;
                        wr_bank   = !cur_reg;
                        wr_addr   = piece_addr[AW-1:0];
                        wr_data   = piece_rect;
                        pcnt_next = pcnt_reg + CW'(1);
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                end
                if (piece_reg == PC_TOP)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_CUT_RD;
                end
                else
                begin
                    piece_next = piece_reg + 2'd1;
                end
            end

            S_DROP_I_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    idx_next   = '0;
                    kept_next  = '0;
                    state_next = S_PACK_RD;
                end
                else
                begin
                    state_next = S_DROP_I_EV;
                end
            end

            S_DROP_I_EV:
            begin
                if (rd_data.dead)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_DROP_I_RD;
                end
                else
                begin
                    ri_next    = rd_data;
                    jdx_next   = idx_reg + CW'(1);
                    state_next = S_DROP_J_RD;
                end
            end

            S_DROP_J_RD:
            begin
                rd_addr = jdx_reg[AW-1:0];
                if (jdx_reg == cnt_reg)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_DROP_I_RD;
                end
                else
                begin
                    state_next = S_DROP_J_EV;
                end
            end

            S_DROP_J_EV:
            begin
                if (!rd_data.dead && raa_pkg::contains(rd_data, ri_reg))
                begin
                    // outer entry swallowed by a later one
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg[AW-1:0];
                    wr_data      = ri_reg;
                    wr_data.dead = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                    state_next   = S_DROP_I_RD;
                end
                else
                begin
                    if (!rd_data.dead && raa_pkg::contains(ri_reg, rd_data))
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = jdx_reg[AW-1:0];
                        wr_data      = rd_data;
                        wr_data.dead = 1'b1;
                    end
                    jdx_next   = jdx_reg + CW'(1);
                    state_next = S_DROP_J_RD;
                end
            end

            S_PACK_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    cnt_next   = kept_reg;
                    cur_next   = !cur_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PACK_EV;
                end
            end

            S_PACK_EV:
            begin
                if (!rd_data.dead)
                begin
                    wr_en     = 1'b1;
                    wr_bank   = !cur_reg;
                    wr_addr   = kept_reg[AW-1:0];
                    wr_data   = rd_data;
                    kept_next = kept_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_PACK_RD;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            cnt_next  = CW'(1);
            gw_next   = 1'b1;
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= CW'(1);
            cur_reg   <= 1'b0;
            cw_reg    <= '0;
            ch_reg    <= '0;
            gw_reg    <= 1'b1;
            pend_reg  <= 1'b1;
            lost_reg  <= 1'b0;
            fail_reg  <= 1'b0;
            found_reg <= 1'b0;
            pass_reg  <= 1'b0;
            piece_reg <= PC_RIGHT;
            idx_reg   <= '0;
            jdx_reg   <= '0;
            kept_reg  <= '0;
            rem_reg   <= '0;
            pcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            cw_reg    <= cw_next;
            ch_reg    <= ch_next;
            gw_reg    <= gw_next;
            pend_reg  <= pend_next;
            lost_reg  <= lost_next;
            fail_reg  <= fail_next;
            found_reg <= found_next;
            pass_reg  <= pass_next;
            piece_reg <= piece_next;
            idx_reg   <= idx_next;
            jdx_reg   <= jdx_next;
            kept_reg  <= kept_next;
            rem_reg   <= rem_next;
            pcnt_reg  <= pcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        h_reg    <= h_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        rr_reg   <= rr_next;
        rb_reg   <= rb_next;
        best_reg <= best_next;
        area_reg <= area_next;
        e0_reg   <= e0_next;
        ov_reg   <= ov_next;
        ri_reg   <= ri_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("free count beyond list depth");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !pend_reg) |-> !wr_en)
        else $error("memory write while idle");

    a_pack_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PACK_EV) |-> (kept_reg <= idx_reg))
        else $error("compaction write ahead of read");

    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && fail_reg) |-> (x_reg == '0 && y_reg == '0))
        else $error("failed request with nonzero position");

endmodule

`default_nettype wire

FILE: hw/rtl/rect_atlas_allocator.sv
// rect_atlas_allocator: top level with config registers, result register and list engine
// depends on raa_pkg, raa_free_mem and raa_engine
`timescale 1ns / 1ps
`default_nettype none

//  channel   signals                        beat fields
//  ------    -------------------------      ---------------------------------
//  request   in_valid / in_ready            req_width, req_height
//  result    out_valid / out_ready          status, pos_x, pos_y
//  config    cfg_we, cfg_index, cfg_data    one register per write, no wait
//
//  one request beat at a time; the free list is searched with a read and an evaluate state
//  per entry, repeated after every canvas growth step
//  exact mode adds two cut passes (a read and an evaluate state per entry plus four
//  pieces per overlapped entry), a pairwise containment sweep and a compaction
//  pass, all bound by the single memory read port
//  fast mode adds a pick read and evaluate after the search, plus a push when the area is split
//  after reset or a config write to a known register index, the list is seeded before a request is taken
//  a finished result sits in the output register so the next request is taken
//  while it waits; the engine stalls only when a second result is ready

module rect_atlas_allocator #(
    parameter int FREE_LIST_DEPTH = raa_pkg::FREE_LIST_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire raa_pkg::req_t                         in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output raa_pkg::res_t                              out_data,
    input  wire logic                                  cfg_we,
    input  wire logic [raa_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [raa_pkg::COORD_BITS-1:0]        cfg_data
);

    localparam int AW = $clog2(FREE_LIST_DEPTH);

    raa_pkg::cfg_t   cfg_reg;
    logic            cfg_hit;
    logic            out_valid_reg;
    raa_pkg::res_t   out_data_reg;

    logic            res_valid;
    logic            res_ready;
    raa_pkg::res_t   res_data;

    // memory port between engine and storage
    logic            wr_en;
    logic            wr_bank;
    logic [AW-1:0]   wr_addr;
    raa_pkg::rect_t  wr_data;
    logic            rd_bank;
    logic [AW-1:0]   rd_addr;
    raa_pkg::rect_t  rd_data;

    // only known register indexes clear the list
    always_comb
    begin
        unique case (cfg_index)
            raa_pkg::CFG_INIT_WIDTH,
            raa_pkg::CFG_INIT_HEIGHT,
            raa_pkg::CFG_MAX_WIDTH,
            raa_pkg::CFG_MAX_HEIGHT,
            raa_pkg::CFG_FAST_MODE:  cfg_hit = cfg_we;
            default:                 cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_width  <= raa_pkg::COORD_BITS'(256);
            cfg_reg.init_height <= raa_pkg::COORD_BITS'(256);
            cfg_reg.max_width   <= raa_pkg::COORD_BITS'(4096);
            cfg_reg.max_height  <= raa_pkg::COORD_BITS'(4096);
            cfg_reg.fast_mode   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                raa_pkg::CFG_INIT_WIDTH:  cfg_reg.init_width  <= cfg_data;
                raa_pkg::CFG_INIT_HEIGHT: cfg_reg.init_height <= cfg_data;
                raa_pkg::CFG_MAX_WIDTH:   cfg_reg.max_width   <= cfg_data;
                raa_pkg::CFG_MAX_HEIGHT:  cfg_reg.max_height  <= cfg_data;
                raa_pkg::CFG_FAST_MODE:   cfg_reg.fast_mode   <= cfg_data[0];
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // result register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    raa_free_mem #(
        .FREE_LIST_DEPTH (FREE_LIST_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_bank (wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_bank (rd_bank),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    raa_engine #(
        .FREE_LIST_DEPTH (FREE_LIST_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .clear     (cfg_hit),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_bank   (rd_bank),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

endmodule

`default_nettype wire
